>>> design/tiled_pixel_address_gen_macros.svh
// assertion macros shared by the tiled pixel address generator
`ifndef TILED_PIXEL_ADDRESS_GEN_MACROS_SVH
`define TILED_PIXEL_ADDRESS_GEN_MACROS_SVH

// checked on every rising edge outside reset
`define TPAG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define TPAG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/tpag_pkg.sv
// shared types and constants of the tiled pixel address generator
`timescale 1ns / 1ps

package tpag_pkg;

  localparam int COORD_W    = 14;
  localparam int TILE_BITS  = 7;
  localparam int INDEX_W    = 2 * TILE_BITS;
  localparam int TILE_A_W   = COORD_W + TILE_BITS;
  localparam int DIM_W      = 15;
  localparam int BPP_W      = 5;
  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURFACE_WIDTH  = 3'd0,
    REG_SURFACE_HEIGHT = 3'd1,
    REG_TILED_BYTES    = 3'd2,
    REG_LINEAR_BYTES   = 3'd3,
    REG_TO_LINEAR      = 3'd4,
    REG_TILED_BASE     = 3'd5,
    REG_LINEAR_BASE    = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0]  surface_width;
    logic [DIM_W-1:0]  surface_height;
    logic [BPP_W-1:0]  tiled_bytes;
    logic [BPP_W-1:0]  linear_bytes;
    logic              to_linear;
    logic [ADDR_W-1:0] tiled_base;
    logic [ADDR_W-1:0] linear_base;
  } cfg_t;

  // classified request as it travels from front to back
  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [TILE_A_W-1:0] tile_a;
    logic                last;
  } item_t;

endpackage

>>> design/tiled_pixel_address_gen.sv
// top level of the tiled pixel address generator
`timescale 1ns / 1ps

// Tiled pixel address generator. Each request carries one pixel coordinate
// (pixel_x, pixel_y) and yields one result: the source and destination byte
// addresses for copying that pixel between a surface tiled in 128x128 blocks
// and the same surface in row-major layout, plus last_pixel, set for the
// bottom-right pixel. The direction follows to_linear (1: tiled to linear).
// Throughput is one request per clock; in_stall only rises when the output
// is held by out_stall long enough to fill the pipeline and the two-entry
// queue. From the edge that accepts a request, it passes the front
// register, then the queue slot, two multiply stages and the output
// register before its result is offered. The multiply stages form the
// multiplier chain (row pitch product, then bytes-per-pixel scaling) in
// the back end. All sums wrap modulo 2^32. Configuration registers are
// written through the cfg port, which is always ready; writes must only
// happen while no request is in flight. Unknown register indices are
// ignored.
module tiled_pixel_address_gen import tpag_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COORD_W-1:0]   pixel_x,
  input  logic [COORD_W-1:0]   pixel_y,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    src_address,
  output logic [ADDR_W-1:0]    dst_address,
  output logic                 last_pixel
);

  cfg_t  cfg;

  // front to queue
  logic  front_valid;
  item_t front_item;
  logic  queue_full;

  // queue to back
  logic  queue_valid;
  item_t queue_item;
  logic  back_ready;

  // register file: always takes a write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.surface_width  <= DIM_W'(1);
      cfg.surface_height <= DIM_W'(1);
      cfg.tiled_bytes    <= BPP_W'(4);
      cfg.linear_bytes   <= BPP_W'(4);
      cfg.to_linear      <= 1'b1;
      cfg.tiled_base     <= '0;
      cfg.linear_base    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SURFACE_WIDTH:  cfg.surface_width  <= cfg_data[DIM_W-1:0];
        REG_SURFACE_HEIGHT: cfg.surface_height <= cfg_data[DIM_W-1:0];
        REG_TILED_BYTES:    cfg.tiled_bytes    <= cfg_data[BPP_W-1:0];
        REG_LINEAR_BYTES:   cfg.linear_bytes   <= cfg_data[BPP_W-1:0];
        REG_TO_LINEAR:      cfg.to_linear      <= cfg_data[0];
        REG_TILED_BASE:     cfg.tiled_base     <= cfg_data;
        REG_LINEAR_BASE:    cfg.linear_base    <= cfg_data;
        default: begin
          // index beyond the register list: write dropped
        end
      endcase
    end
  end

  // front end: tile index and last-pixel check, one request per clock unless held by a full queue
  tpag_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .item_valid (front_valid),
    .item       (front_item),
    .item_full  (queue_full)
  );

  // decoupling queue, lets either side stall on its own
  tpag_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_item  (front_item),
    .full       (queue_full),
    .pop_valid  (queue_valid),
    .pop_item   (queue_item),
    .pop_ready  (back_ready)
  );

  // back end: address arithmetic and the output register
  tpag_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (queue_valid),
    .item        (queue_item),
    .item_ready  (back_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .src_address (src_address),
    .dst_address (dst_address),
    .last_pixel  (last_pixel)
  );

endmodule

>>> design/tpag_front.sv
// front end: takes requests, forms the tile-local index and the last-pixel flag
`timescale 1ns / 1ps

module tpag_front import tpag_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  output logic               item_valid,
  output item_t              item,
  input  logic               item_full
);

  logic  advance;
  item_t item_next;
  logic [INDEX_W-1:0] index_next;

  assign advance  = !item_valid || !item_full;
  assign in_stall = !advance;

  // bit order from lsb: x0 x1 y0 x2 y1 y2 x3 y3 y4 y5 y6 x4 x5 x6
  assign index_next = {pixel_x[6:4], pixel_y[6:3], pixel_x[3], pixel_y[2:1],
                       pixel_x[2], pixel_y[0], pixel_x[1:0]};

  always_comb begin
    item_next.x      = pixel_x;
    item_next.y      = pixel_y;
    item_next.tile_a = {pixel_x[COORD_W-1:TILE_BITS], index_next};
    // x == width-1 written as x+1 == width, so a zero width never matches
    item_next.last   = ((DIM_W'(pixel_x) + DIM_W'(1)) == cfg.surface_width) &&
                       ((DIM_W'(pixel_y) + DIM_W'(1)) == cfg.surface_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (advance) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      item <= item_next;
    end
  end

endmodule

>>> design/tpag_queue.sv
// short queue decoupling the front end from the address pipeline
`timescale 1ns / 1ps

module tpag_queue import tpag_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  full,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_ready
);

`include "tiled_pixel_address_gen_macros.svh"

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `TPAG_ASSERT_ALWAYS(a_count_bound, clk, rst || (count <= QCNT_W'(QUEUE_DEPTH)), "queue overfilled")
  `TPAG_ASSERT(a_count_up, clk, rst, push && !pop |=> count == $past(count) + QCNT_W'(1), "queue count lost a push")
  `TPAG_ASSERT(a_count_down, clk, rst, pop && !push |=> count == $past(count) - QCNT_W'(1), "queue count lost a pop")

endmodule

>>> design/tpag_back.sv
// back end: three-stage multiply and add pipeline with the output register
`timescale 1ns / 1ps

module tpag_back import tpag_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              item_valid,
  input  item_t             item,
  output logic              item_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] src_address,
  output logic [ADDR_W-1:0] dst_address,
  output logic              last_pixel
);

`include "tiled_pixel_address_gen_macros.svh"

  localparam int PLIN_W = COORD_W + DIM_W;
  localparam int PCY_W  = COORD_W - TILE_BITS + DIM_W;
  localparam int TA_W   = TILE_A_W + BPP_W;
  localparam int TB_W   = PCY_W + BPP_W;

  logic s3_free;
  logic s2_free;
  logic s1_free;

  // stage 1: products by the row pitch and the scaled tile term
  logic                s1_valid;
  logic [COORD_W-1:0]  s1_x;
  logic                s1_last;
  logic [PLIN_W-1:0]   s1_p_lin;
  logic [PCY_W-1:0]    s1_p_cy;
  logic [TA_W-1:0]     s1_t_a;

  // stage 2: scale by bytes per pixel
  logic                s2_valid;
  logic                s2_last;
  logic [ADDR_W-1:0]   s2_lin;
  logic [TB_W-1:0]     s2_t_b;
  logic [TA_W-1:0]     s2_t_a;

  logic [ADDR_W-1:0]   tiled_addr;
  logic [ADDR_W-1:0]   linear_addr;

  assign s3_free    = !out_valid || !out_stall;
  assign s2_free    = !s2_valid || s3_free;
  assign s1_free    = !s1_valid || s2_free;
  assign item_ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= item_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && item_valid) begin
      s1_x     <= item.x;
      s1_last  <= item.last;
      s1_p_lin <= PLIN_W'(item.y) * PLIN_W'(cfg.surface_width);
      s1_p_cy  <= PCY_W'(item.y[COORD_W-1:TILE_BITS]) * PCY_W'(cfg.surface_width);
      s1_t_a   <= TA_W'(item.tile_a) * TA_W'(cfg.tiled_bytes);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_last <= s1_last;
      s2_t_a  <= s1_t_a;
      s2_lin  <= ADDR_W'((ADDR_W'(s1_x) + ADDR_W'(s1_p_lin)) * ADDR_W'(cfg.linear_bytes));
      s2_t_b  <= TB_W'(s1_p_cy) * TB_W'(cfg.tiled_bytes);
    end
  end

  // coarse y term carries the factor 128 as a shift
  assign tiled_addr  = cfg.tiled_base + ADDR_W'(s2_t_a) + ADDR_W'({s2_t_b, 7'b0});
  assign linear_addr = cfg.linear_base + s2_lin;

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid) begin
      src_address <= cfg.to_linear ? tiled_addr : linear_addr;
      dst_address <= cfg.to_linear ? linear_addr : tiled_addr;
      last_pixel  <= s2_last;
    end
  end

  `TPAG_ASSERT(a_s1_hold, clk, rst, s1_valid && !s2_free |=> s1_valid && $stable(s1_t_a), "stage 1 dropped a blocked request")
  `TPAG_ASSERT(a_s2_hold, clk, rst, s2_valid && !s3_free |=> s2_valid && $stable(s2_lin), "stage 2 dropped a blocked request")

endmodule

>>> bench/tb_top.sv
// self-checking testbench for the tiled pixel address generator
`timescale 1ns / 1ps

module tb_top;
  import tpag_pkg::*;

  // request and result pacing
  localparam int GAP_MAX         = 17;
  localparam int HOLD_CYCLES     = 250;   // long receiver hold-off to back the pipe up
  localparam int HOLD_AT_FIRST   = 400;
  localparam int HOLD_AT_SECOND  = 1200;
  localparam int SETTLE_CYCLES   = 8;     // pipeline latency plus margin
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int REQS_PER_PHASE  = 205;
  localparam int REPORT_CAP      = 100;

  // register index past the end of the map, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // clears the seven in-tile bits of a coordinate
  localparam logic [COORD_W-1:0]   COARSE_MASK = 14'h3f80;
  localparam int                   MAX_COORD   = 16384;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pixel_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic              last;
  } copy_addr_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [COORD_W-1:0]   pixel_x   = '0;
  logic [COORD_W-1:0]   pixel_y   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    src_address;
  logic [ADDR_W-1:0]    dst_address;
  logic                 last_pixel;

  tiled_pixel_address_gen u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .src_address (src_address),
    .dst_address (dst_address),
    .last_pixel  (last_pixel)
  );

  // bench copy of the register file, updated as each write is accepted
  cfg_t       surface_cfg;
  pixel_req_t pixel_backlog[$];     // requests waiting for the driver
  copy_addr_t expected_copies[$];   // predicted results in request order

  pixel_req_t tx_req;
  copy_addr_t rx_want;
  int         tx_gap       = 0;
  int         rx_gap       = 0;
  int         rx_next;
  int         hold_left    = 0;
  int         sent_count   = 0;
  int         queued_count = 0;
  int         quiet_count  = 0;
  int         fail_count   = 0;
  logic       tx_idle_on   = 1'b1;
  logic       rx_idle_on   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    // cap the log, keep counting
    if (fail_count < REPORT_CAP) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic int draw_gap(input logic enable);
    return enable ? int'($urandom_range(0, GAP_MAX)) : 0;
  endfunction

  // in-tile index, bits from lsb: x0 x1 y0 x2 y1 y2 x3 y3 y4 y5 y6 x4 x5 x6
  function automatic logic [INDEX_W-1:0] swizzle_index(input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y);
    return {x[6], x[5], x[4], y[6], y[5], y[4], y[3], x[3],
            y[2], y[1], x[2], y[0], x[1], x[0]};
  endfunction

  // source and destination of a one-pixel copy, all sums modulo 2^32
  function automatic copy_addr_t predict_copy(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y);
    logic [ADDR_W-1:0] width32, height32, tbpp32, lbpp32;
    logic [ADDR_W-1:0] x_hi, y_hi, tile_part, row_part;
    logic [ADDR_W-1:0] tiled_addr, linear_addr, last_x, last_y;
    copy_addr_t        r;
    width32     = {17'd0, surface_cfg.surface_width};
    height32    = {17'd0, surface_cfg.surface_height};
    tbpp32      = {27'd0, surface_cfg.tiled_bytes};
    lbpp32      = {27'd0, surface_cfg.linear_bytes};
    x_hi        = {18'd0, x & COARSE_MASK};
    y_hi        = {18'd0, y & COARSE_MASK};
    tile_part   = ({18'd0, swizzle_index(x, y)} + x_hi * 32'd128) * tbpp32;
    row_part    = (y_hi * width32) * tbpp32;
    tiled_addr  = surface_cfg.tiled_base + tile_part + row_part;
    linear_addr = surface_cfg.linear_base + ({18'd0, x} + {18'd0, y} * width32) * lbpp32;
    // a zero size wraps to all ones and can never match a coordinate
    last_x      = width32 - 32'd1;
    last_y      = height32 - 32'd1;
    if (surface_cfg.to_linear) begin
      r.src = tiled_addr;
      r.dst = linear_addr;
    end else begin
      r.src = linear_addr;
      r.dst = tiled_addr;
    end
    r.last = ({18'd0, x} == last_x) && ({18'd0, y} == last_y);
    return r;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [ADDR_W-1:0] data);
    case (idx)
      REG_SURFACE_WIDTH:  surface_cfg.surface_width  = data[DIM_W-1:0];
      REG_SURFACE_HEIGHT: surface_cfg.surface_height = data[DIM_W-1:0];
      REG_TILED_BYTES:    surface_cfg.tiled_bytes    = data[BPP_W-1:0];
      REG_LINEAR_BYTES:   surface_cfg.linear_bytes   = data[BPP_W-1:0];
      REG_TO_LINEAR:      surface_cfg.to_linear      = data[0];
      REG_TILED_BASE:     surface_cfg.tiled_base     = data;
      REG_LINEAR_BASE:    surface_cfg.linear_base    = data;
      default: ;
    endcase
  endfunction

  function automatic cfg_t make_surface(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                        input logic [BPP_W-1:0] tb, input logic [BPP_W-1:0] lb,
                                        input logic tl, input logic [ADDR_W-1:0] tbase,
                                        input logic [ADDR_W-1:0] lbase);
    cfg_t c;
    c.surface_width  = w;
    c.surface_height = h;
    c.tiled_bytes    = tb;
    c.linear_bytes   = lb;
    c.to_linear      = tl;
    c.tiled_base     = tbase;
    c.linear_base    = lbase;
    return c;
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return 15'd1;
      1:       return 15'd16384;
      2:       return 15'd0;
      3:       return 15'd32767;
      4, 5, 6: return 15'($urandom_range(1, 300));
      default: return 15'($urandom_range(1, MAX_COORD));
    endcase
  endfunction

  function automatic logic [BPP_W-1:0] random_bpp();
    case ($urandom_range(0, 7))
      0:       return 5'd0;
      1:       return 5'd31;
      2:       return 5'd16;
      3:       return 5'd1;
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] random_base();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // mostly pixels inside the surface, some last pixels, tile edges and noise
  function automatic pixel_req_t random_pixel();
    int         lim_x, lim_y, pick;
    pixel_req_t r;
    lim_x = (surface_cfg.surface_width == 0 || surface_cfg.surface_width > MAX_COORD) ?
            MAX_COORD : int'(surface_cfg.surface_width);
    lim_y = (surface_cfg.surface_height == 0 || surface_cfg.surface_height > MAX_COORD) ?
            MAX_COORD : int'(surface_cfg.surface_height);
    pick  = $urandom_range(0, 99);
    if (pick < 70) begin
      r.x = 14'($urandom_range(0, lim_x - 1));
      r.y = 14'($urandom_range(0, lim_y - 1));
    end else if (pick < 80) begin
      r.x = 14'(lim_x - 1);
      r.y = 14'(lim_y - 1);
    end else if (pick < 88) begin
      r.x = {7'($urandom()), ($urandom_range(0, 1) != 0) ? 7'h7f : 7'h00};
      r.y = {7'($urandom()), ($urandom_range(0, 1) != 0) ? 7'h7f : 7'h00};
    end else begin
      r.x = 14'($urandom());
      r.y = 14'($urandom());
    end
    return r;
  endfunction

  task automatic queue_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    pixel_req_t r;
    r.x = x;
    r.y = y;
    pixel_backlog.push_back(r);
    queued_count++;
  endtask

  // valid stays high across back-to-back writes, the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
  endtask

  // every register written, junk in the unused upper bits and a stray index
  task automatic program_surface(input cfg_t c);
    write_reg(REG_UNUSED,         $urandom());
    write_reg(REG_SURFACE_WIDTH,  {17'($urandom()), c.surface_width});
    write_reg(REG_SURFACE_HEIGHT, {17'($urandom()), c.surface_height});
    write_reg(REG_TILED_BYTES,    {27'($urandom()), c.tiled_bytes});
    write_reg(REG_LINEAR_BYTES,   {27'($urandom()), c.linear_bytes});
    write_reg(REG_TO_LINEAR,      {31'($urandom()), c.to_linear});
    write_reg(REG_TILED_BASE,     c.tiled_base);
    write_reg(REG_LINEAR_BASE,    c.linear_base);
    cfg_valid <= 1'b0;
  endtask

  // wait for every request to go in and every result to come out, then let the pipe settle
  task automatic drain_and_settle();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || in_valid || sent_count != queued_count ||
           expected_copies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // request driver: offers the backlog in order, random idle gaps between requests while idling is on
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      tx_gap     <= 0;
      sent_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_copies.push_back(predict_copy(pixel_x, pixel_y));
        sent_count <= sent_count + 1;
      end
      // payload only moves once the current request is gone
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          tx_req   = pixel_backlog.pop_front();
          pixel_x  <= tx_req.x;
          pixel_y  <= tx_req.y;
          in_valid <= 1'b1;
          tx_gap   <= draw_gap(tx_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each result against the oldest prediction, stalls at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_gap    <= 0;
    end else begin
      rx_next = (rx_gap != 0) ? rx_gap - 1 : 0;
      if (out_valid && !out_stall) begin
        if (expected_copies.size() == 0) begin
          report_mismatch($sformatf("unexpected result src %h dst %h last %b",
                                    src_address, dst_address, last_pixel));
        end else begin
          rx_want = expected_copies.pop_front();
          if (src_address !== rx_want.src)
            report_mismatch($sformatf("src_address %h, want %h", src_address, rx_want.src));
          if (dst_address !== rx_want.dst)
            report_mismatch($sformatf("dst_address %h, want %h", dst_address, rx_want.dst));
          if (last_pixel !== rx_want.last)
            report_mismatch($sformatf("last_pixel %b, want %b", last_pixel, rx_want.last));
        end
        rx_next = draw_gap(rx_idle_on);
      end
      rx_gap    <= rx_next;
      out_stall <= (rx_next != 0) || (hold_left != 0);
    end
  end

  // long hold-off on the result side while requests keep coming, fills the queue
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (in_valid && !in_stall &&
                 (sent_count == HOLD_AT_FIRST || sent_count == HOLD_AT_SECOND)) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // watchdog: any accepted request, result or write counts as progress
  always @(posedge clk) begin
    if (rst) begin
      quiet_count <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("FAIL tiled_pixel_address_gen");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    pixel_req_t r;
    // register values after reset
    surface_cfg = make_surface(15'd1, 15'd1, 5'd4, 5'd4, 1'b1, 32'd0, 32'd0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: a 1x1 surface, so only the origin is the last pixel
    queue_pixel(14'd0, 14'd0);
    queue_pixel(14'd16383, 14'd16383);
    queue_pixel(14'd127, 14'd127);
    queue_pixel(14'd128, 14'd0);
    queue_pixel(14'd0, 14'd128);
    queue_pixel(14'd16383, 14'd0);
    drain_and_settle();

    // largest legal surface, widest pixels, linear to tiled, bases at the top
    program_surface(make_surface(15'd16384, 15'd16384, 5'd16, 5'd16, 1'b0,
                                 32'hffff_ffff, 32'hffff_ffff));
    queue_pixel(14'd16383, 14'd16383);
    queue_pixel(14'd0, 14'd0);
    queue_pixel(14'h2aaa, 14'h1555);
    queue_pixel(14'h1555, 14'h2aaa);
    queue_pixel(14'd16383, 14'd0);
    drain_and_settle();

    // zero sizes and zero bytes per pixel: addresses collapse to the bases
    program_surface(make_surface(15'd0, 15'd0, 5'd0, 5'd0, 1'b1,
                                 $urandom(), $urandom()));
    queue_pixel(14'd0, 14'd0);
    queue_pixel(14'd16383, 14'd16383);
    queue_pixel(14'd100, 14'd5);
    drain_and_settle();

    // all-ones register fields, past anything a coordinate can reach
    program_surface(make_surface(15'd32767, 15'd32767, 5'd31, 5'd31, 1'b0,
                                 32'h8000_0000, 32'h7fff_ffff));
    queue_pixel(14'd16383, 14'd16383);
    queue_pixel(14'd0, 14'd0);
    queue_pixel(14'd127, 14'd16383);
    drain_and_settle();

    // narrow surface: last pixel, the pixel above it, the start of its row, and one column outside
    program_surface(make_surface(15'd300, 15'd2, 5'd1, 5'd3, 1'b1,
                                 32'h0000_1000, 32'h0010_0000));
    queue_pixel(14'd299, 14'd1);
    queue_pixel(14'd299, 14'd0);
    queue_pixel(14'd0, 14'd1);
    queue_pixel(14'd300, 14'd1);
    drain_and_settle();

    // random surfaces with random pixels; some phases run with no idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_surface(make_surface(random_dim(), random_dim(), random_bpp(), random_bpp(),
                                   1'($urandom_range(0, 1)), random_base(), random_base()));
      tx_idle_on <= ($urandom_range(0, 3) != 0);
      rx_idle_on <= ($urandom_range(0, 3) != 0);
      for (int i = 0; i < REQS_PER_PHASE; i++) begin
        r = random_pixel();
        queue_pixel(r.x, r.y);
      end
      drain_and_settle();
    end

    if (expected_copies.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_copies.size()));
    if (fail_count == 0) begin
      $display("PASS tiled_pixel_address_gen");
    end else begin
      $display("FAIL tiled_pixel_address_gen");
    end
    $finish;
  end

endmodule
